// File: rtl/core/gct_pkg.sv
// Shared types, constants and helper functions for the gated countdown timer.
// Used by every module under rtl/core; depends on nothing.
package gct_pkg;

  // Setpoint clamp bound in seconds
  localparam int unsigned MAX_SECONDS = 65535;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REM_W = 26;
  localparam int unsigned DELAY_W = 27;

  localparam logic [REM_W-1:0] MS_PER_S = 26'd1000;
  localparam logic [REM_W-1:0] ROUND_UP_MS = 26'd999;
  localparam logic [15:0] QUIET_MAX = 16'hFFFF;
  localparam logic [DELAY_W-1:0] DELAY_MAX = 27'h7FFFFFF;

  // floor(x / 1000) for x < 2**26: (x >> 3) * RECIP >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP = 24'd8589935;

  localparam logic [15:0] RESET_COUNTDOWN_S = 16'd10;
  localparam logic [15:0] RESET_RELEASE_S = 16'd5;
  localparam logic [7:0] RESET_DEBOUNCE_MS = 8'd50;
  localparam logic [REM_W-1:0] RESET_SETPOINT_MS = 26'd10000;
  localparam logic [REM_W-1:0] RESET_RELEASE_MS = 26'd5000;

  localparam logic REQ_MANUAL_RESET = 1'b1;
  localparam logic MODE_LATCH = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUNNING,
    PH_PAUSED,
    PH_OUT
  } phase_t;

  typedef enum logic [2:0] {
    REG_COUNTDOWN,
    REG_RELEASE,
    REG_MODE,
    REG_DEBOUNCE,
    REG_ACTIVE_LOW
  } reg_idx_t;

  typedef struct packed {
    logic req_type;
    logic [15:0] elapsed_ms;
    logic gate_level;
    logic clear_level;
  } req_item_t;

  typedef struct packed {
    logic output_on;
    logic [1:0] timer_state;
    logic [15:0] remaining_seconds;
    logic phase_changed;
  } res_item_t;

  typedef struct packed {
    logic [REM_W-1:0] setpoint_ms;
    logic [REM_W-1:0] release_ms;
    logic mode;
    logic [7:0] debounce_ms;
    logic active_low;
  } cfg_t;

  typedef struct packed {
    logic rearm_if_idle;
    logic clear_delay;
    logic [REM_W-1:0] setpoint_ms;
  } cfg_evt_t;

  typedef struct packed {
    logic output_on;
    phase_t state;
    logic changed;
    logic [REM_W-1:0] rem_ms;
  } stage_t;

  function automatic logic [15:0] clamp_seconds(input logic [15:0] v);
    logic [15:0] r;
    r = (32'(v) > MAX_SECONDS) ? 16'(MAX_SECONDS) : v;
    return r;
  endfunction

  function automatic logic [REM_W-1:0] ms_of_seconds(input logic [15:0] s);
    logic [REM_W-1:0] r;
    r = REM_W'(s) * MS_PER_S;
    return r;
  endfunction

endpackage

// File: rtl/core/gct_debounce.sv
// Quiet-time debouncer for one asserted-level input.
// Depends on gct_pkg.
module gct_debounce (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed,
  input  logic        step,
  input  logic        sample,
  input  logic [15:0] dt,
  input  logic [7:0]  debounce_ms,
  output logic        stable_next,
  output logic        rise
);

  logic        last_raw;
  logic        stable;
  logic [15:0] quiet;
  logic [16:0] quiet_sum;
  logic [15:0] quiet_sat;
  logic        moved;
  logic        take;

  always_comb begin
    quiet_sum = {1'b0, quiet} + {1'b0, dt};
    quiet_sat = quiet_sum[16] ? gct_pkg::QUIET_MAX : quiet_sum[15:0];
    moved = sample != last_raw;
    take = !moved && (quiet_sat >= {8'd0, debounce_ms}) && (sample != stable);
    stable_next = take ? sample : stable;
    rise = step && take && sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw <= 1'b0;
      stable <= 1'b0;
      quiet <= '0;
    end else if (seed) begin
      last_raw <= sample;
      stable <= sample;
      quiet <= '0;
    end else if (step) begin
      if (moved) begin
        // restart the quiet window
        last_raw <= sample;
        quiet <= '0;
      end else begin
        quiet <= quiet_sat;
        stable <= stable_next;
      end
    end
  end

endmodule

// File: rtl/core/gct_cfg.sv
// APB-style configuration registers with the millisecond setpoints derived on write.
// Depends on gct_pkg.
module gct_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gct_pkg::ADDR_W-1:0]  paddr,
  input  logic [gct_pkg::DATA_W-1:0]  pwdata,
  output logic [gct_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output gct_pkg::cfg_t               cfg,
  output gct_pkg::cfg_evt_t           evt
);

  logic              wr;
  gct_pkg::reg_idx_t idx;
  logic [15:0]       countdown_s;
  logic [15:0]       release_s;
  logic [15:0]       countdown_new;
  logic [15:0]       release_new;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = gct_pkg::reg_idx_t'(paddr[gct_pkg::ADDR_W-1:2]);
  assign countdown_new = gct_pkg::clamp_seconds(pwdata[15:0]);
  assign release_new = gct_pkg::clamp_seconds(pwdata[15:0]);

  always_comb begin
    evt.rearm_if_idle = wr && (idx == gct_pkg::REG_COUNTDOWN);
    evt.clear_delay = wr && (idx == gct_pkg::REG_MODE);
    evt.setpoint_ms = gct_pkg::ms_of_seconds(countdown_new);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown_s <= gct_pkg::RESET_COUNTDOWN_S;
      release_s <= gct_pkg::RESET_RELEASE_S;
      cfg.setpoint_ms <= gct_pkg::RESET_SETPOINT_MS;
      cfg.release_ms <= gct_pkg::RESET_RELEASE_MS;
      cfg.mode <= gct_pkg::MODE_LATCH;
      cfg.debounce_ms <= gct_pkg::RESET_DEBOUNCE_MS;
      cfg.active_low <= 1'b1;
    end else if (wr) begin
      case (idx)
        gct_pkg::REG_COUNTDOWN: begin
          countdown_s <= countdown_new;
          cfg.setpoint_ms <= evt.setpoint_ms;
        end
        gct_pkg::REG_RELEASE: begin
          release_s <= release_new;
          cfg.release_ms <= gct_pkg::ms_of_seconds(release_new);
        end
        gct_pkg::REG_MODE: cfg.mode <= pwdata[0];
        gct_pkg::REG_DEBOUNCE: cfg.debounce_ms <= pwdata[7:0];
        gct_pkg::REG_ACTIVE_LOW: cfg.active_low <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gct_pkg::REG_COUNTDOWN: prdata = {16'd0, countdown_s};
      gct_pkg::REG_RELEASE: prdata = {16'd0, release_s};
      gct_pkg::REG_MODE: prdata = {31'd0, cfg.mode};
      gct_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg.debounce_ms};
      gct_pkg::REG_ACTIVE_LOW: prdata = {31'd0, cfg.active_low};
      default: prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/gct_core.sv
// Timer state update: debouncers, phase machine, countdown and delay-off counters.
// Loads the first pipeline register. Depends on gct_pkg and gct_debounce.
module gct_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  gct_pkg::req_item_t  item,
  input  gct_pkg::cfg_t       cfg,
  input  gct_pkg::cfg_evt_t   evt,
  input  logic                adv,
  output logic                s1_valid,
  output gct_pkg::stage_t     s1
);

  logic                          started;
  gct_pkg::phase_t               phase;
  gct_pkg::phase_t               phase_next;
  logic                          drive_next;
  logic [gct_pkg::REM_W-1:0]     rem;
  logic [gct_pkg::REM_W-1:0]     rem_next;
  logic [gct_pkg::DELAY_W-1:0]   delay;
  logic [gct_pkg::DELAY_W-1:0]   delay_next;
  logic [gct_pkg::DELAY_W:0]     delay_sum;
  logic [gct_pkg::DELAY_W-1:0]   delay_sat;
  logic                          is_tick;
  logic                          gate;
  logic                          clr;
  logic                          dbn_seed;
  logic                          dbn_step;
  logic                          gate_st;
  logic                          gate_rise;
  logic                          clr_st;
  logic                          clr_rise;

  assign is_tick = item.req_type != gct_pkg::REQ_MANUAL_RESET;
  assign gate = item.gate_level ^ cfg.active_low;
  assign clr = item.clear_level ^ cfg.active_low;
  assign dbn_seed = accept && is_tick && !started;
  assign dbn_step = accept && is_tick && started;

  gct_debounce u_gate (
    .clk         (clk),
    .rst         (rst),
    .seed        (dbn_seed),
    .step        (dbn_step),
    .sample      (gate),
    .dt          (item.elapsed_ms),
    .debounce_ms (cfg.debounce_ms),
    .stable_next (gate_st),
    .rise        (gate_rise)
  );

  gct_debounce u_clear (
    .clk         (clk),
    .rst         (rst),
    .seed        (dbn_seed),
    .step        (dbn_step),
    .sample      (clr),
    .dt          (item.elapsed_ms),
    .debounce_ms (cfg.debounce_ms),
    .stable_next (clr_st),
    .rise        (clr_rise)
  );

  always_comb begin
    delay_sum = {1'b0, delay} + (gct_pkg::DELAY_W + 1)'(item.elapsed_ms);
    delay_sat = delay_sum[gct_pkg::DELAY_W] ? gct_pkg::DELAY_MAX
                                            : delay_sum[gct_pkg::DELAY_W-1:0];
    phase_next = phase;
    rem_next = rem;
    delay_next = delay;
    drive_next = 1'b0;
    if (!is_tick || !started || clr_rise) begin
      // manual reset, first tick or debounced clear edge: back to idle, rearmed
      phase_next = gct_pkg::PH_IDLE;
      rem_next = cfg.setpoint_ms;
      delay_next = '0;
    end else begin
      case (phase)
        gct_pkg::PH_IDLE: begin
          if (gate_st) begin
            rem_next = cfg.setpoint_ms;
            delay_next = '0;
            phase_next = gct_pkg::PH_RUNNING;
          end
        end
        gct_pkg::PH_RUNNING: begin
          if (!gate_st) begin
            phase_next = gct_pkg::PH_PAUSED;
          end else if (rem <= gct_pkg::REM_W'(item.elapsed_ms)) begin
            rem_next = '0;
            delay_next = '0;
            phase_next = gct_pkg::PH_OUT;
            drive_next = 1'b1;
          end else begin
            rem_next = rem - gct_pkg::REM_W'(item.elapsed_ms);
          end
        end
        gct_pkg::PH_PAUSED: begin
          if (gate_st) begin
            phase_next = gct_pkg::PH_RUNNING;
          end
        end
        gct_pkg::PH_OUT: begin
          drive_next = 1'b1;
          if (cfg.mode == gct_pkg::MODE_RELEASE) begin
            delay_next = delay_sat;
            if (delay_sat >= gct_pkg::DELAY_W'(cfg.release_ms)) begin
              rem_next = cfg.setpoint_ms;
              delay_next = '0;
              phase_next = gct_pkg::PH_IDLE;
              drive_next = 1'b0;
            end
          end
        end
        default: begin
          phase_next = gct_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      phase <= gct_pkg::PH_IDLE;
      rem <= gct_pkg::RESET_SETPOINT_MS;
      delay <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        rem <= rem_next;
        delay <= delay_next;
        if (is_tick) begin
          started <= 1'b1;
        end
        s1_valid <= 1'b1;
      end else begin
        if (evt.rearm_if_idle && (phase == gct_pkg::PH_IDLE)) begin
          rem <= evt.setpoint_ms;
          delay <= '0;
        end else if (evt.clear_delay) begin
          delay <= '0;
        end
        if (adv) begin
          s1_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.output_on <= drive_next;
      s1.state <= phase_next;
      s1.changed <= phase_next != phase;
      s1.rem_ms <= rem_next;
    end
  end

endmodule

// File: rtl/core/gct_out.sv
// Result stage: rounds the remaining milliseconds up to seconds and holds the result.
// Depends on gct_pkg.
module gct_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                s1_valid,
  input  gct_pkg::stage_t     s1,
  output logic                res_valid,
  output gct_pkg::res_item_t  res_item
);

  logic [gct_pkg::REM_W-1:0] rounded;
  logic [46:0]               prod;
  logic [15:0]               secs;

  // ceil(ms / 1000) as floor((ms + 999) / 8 * RECIP >> RECIP_SHIFT)
  always_comb begin
    rounded = s1.rem_ms + gct_pkg::ROUND_UP_MS;
    prod = 47'(rounded[gct_pkg::REM_W-1:3]) * 47'(gct_pkg::RECIP);
    secs = prod[gct_pkg::RECIP_SHIFT+15:gct_pkg::RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      res_item.output_on <= s1.output_on;
      res_item.timer_state <= s1.state;
      res_item.remaining_seconds <= secs;
      res_item.phase_changed <= s1.changed;
    end
  end

endmodule

// File: rtl/core/gated_countdown_timer.sv
// Top level of the gated countdown timer: request/result channels and register port.
// Depends on gct_pkg, gct_cfg, gct_core and gct_out.
//
//   channel   signals                               direction
//   request   req_valid, req_ready, req_item        in
//   result    res_valid, res_ready, res_item        out
//   config    psel, penable, pwrite, paddr, pwdata,  in
//             prdata, pready                        out
//
// One request per cycle; its result passes through the stage register (state update
// at acceptance) and then the result register (the seconds rounding multiply
// into the result register). Both stages stall
// together when the result is not taken; req_ready drops only while both hold a request.
// Synchronous reset restores register defaults and idles the timer at once.
module gated_countdown_timer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  gct_pkg::req_item_t          req_item,
  output logic                        res_valid,
  input  logic                        res_ready,
  output gct_pkg::res_item_t          res_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gct_pkg::ADDR_W-1:0]  paddr,
  input  logic [gct_pkg::DATA_W-1:0]  pwdata,
  output logic [gct_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  gct_pkg::cfg_t     cfg;
  gct_pkg::cfg_evt_t evt;
  gct_pkg::stage_t   s1;
  logic              s1_valid;
  logic              adv;
  logic              accept;

  assign adv = !res_valid || res_ready;
  assign req_ready = !s1_valid || adv;
  assign accept = req_valid && req_ready;

  gct_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  gct_core u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (req_item),
    .cfg      (cfg),
    .evt      (evt),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  gct_out u_out (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // output drive is on exactly in the out state
  a_drive_state: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.output_on == (res_item.timer_state == gct_pkg::PH_OUT)))
    else $error("output drive disagrees with timer state");

  // expired countdown shows zero seconds left
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_item.timer_state == gct_pkg::PH_OUT)) |->
      (res_item.remaining_seconds == 16'd0))
    else $error("remaining time nonzero in out state");

  // an empty result register never holds back requests
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request stalled with empty result register");

  // an accepted request with a free result side is held in the stage register
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (accept && !s1_valid && adv) |=> s1_valid)
    else $error("accepted request lost");

endmodule
